// File: rtl/cpr_pkg.sv
// Package: constants, widths and helpers for the conic point residual block.
package cpr_pkg;
   localparam int COORD_FRAC_DEF = 4;
   localparam int COEF_FRAC_DEF  = 24;
   localparam int OUT_FRAC_DEF   = 16;
   localparam int COORD_W = 16;
   localparam int COEF_W  = 32;
   localparam int OUT_W   = 48;
   localparam int CSR_IDX_W = 3;
   localparam int DIST_FRAC = 8;
   localparam int NUM_COEF = 6;
   localparam int ACC_W = 112;
   localparam int QUO_W = 49;
   localparam int PROD_W = 96;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_A = 3'd0,
      REG_COEF_B = 3'd1,
      REG_COEF_C = 3'd2,
      REG_COEF_D = 3'd3,
      REG_COEF_E = 3'd4,
      REG_COEF_F = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] form_value;
      logic signed [OUT_W-1:0] grad_x;
      logic signed [OUT_W-1:0] grad_y;
      logic        [OUT_W-1:0] sqr_dist;
      logic                    grad_zero;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
   } req_type;
endpackage

// File: rtl/cpr_stream_if.sv
// Interface: valid/ready stream channel carrying one payload.
interface cpr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/conic_point_residual.sv
// Top level: conic residual, gradient and approximate squared distance per point.
// One point enters per clock when the output side takes results. The pipeline is
// 4 product/sum stages, then a 2-stage magnitude-squared multiply, then the
// distance quotient built 4 bits per stage over 28 stages (the quotient needs
// the full 112-bit numerator scanned; bits above 48 only flag saturation), then
// an output register. Every stage holds a valid bit and the whole pipe stalls
// together when the output register is held, so apart from those stalls the
// throughput is one request per cycle. The user must write coefficients through
// the csr port only while the pipe is empty; the block does not enforce this.
module conic_point_residual
   import cpr_pkg::*;
#(
   parameter int COORD_FRAC = COORD_FRAC_DEF,
   parameter int COEF_FRAC  = COEF_FRAC_DEF,
   parameter int OUT_FRAC   = OUT_FRAC_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_write_data,
   cpr_stream_if.sink           req_channel,
   cpr_stream_if.source         rsp_channel
);
   localparam int QF = COEF_FRAC + 2 * COORD_FRAC;
   localparam int GF = COEF_FRAC + COORD_FRAC;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STG   = ACC_W / DIV_BITS;
   localparam int NSTG      = 6;

   logic signed [COEF_W-1:0] coef_ff [NUM_COEF];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) coef_ff[i] <= '0;
      end else if (csr_write_enable) begin
         case (csr_index) inside
            REG_COEF_A, REG_COEF_B, REG_COEF_C,
            REG_COEF_D, REG_COEF_E, REG_COEF_F: begin
               coef_ff[csr_index] <= csr_write_data;
            end
            default: ;
         endcase
      end
   end

   // whole-pipe stall: advance when output register is free or drained
   logic advance;
   logic rsp_valid_ff;
   assign advance = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = advance;

   logic vld_ff [NSTG + DIV_STG];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG + DIV_STG; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_channel.valid;
         for (int i = 1; i < NSTG + DIV_STG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // round half up and saturate to 48 bits
   function automatic logic [OUT_W:0] rescale(input logic signed [ACC_W-1:0] v, input int frac);
      logic signed [ACC_W-1:0] r;
      logic ovf;
      begin
         if (frac > OUT_FRAC) r = (v + (ACC_W'(1) <<< (frac - OUT_FRAC - 1))) >>> (frac - OUT_FRAC);
         else r = v <<< (OUT_FRAC - frac);
         ovf = (r > $signed({{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}}))
            || (r < -$signed({{(ACC_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}}));
         if (!ovf) rescale = {1'b0, r[OUT_W-1:0]};
         else if (r[ACC_W-1]) rescale = {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
         else rescale = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // stage 1: coefficient times coordinate
   logic signed [COORD_W-1:0]  x1_ff, y1_ff;
   logic signed [COEF_W+COORD_W-1:0] ax1_ff, bx1_ff, by1_ff, cy1_ff, dx1_ff, ey1_ff;
   logic signed [COEF_W+COORD_W-1:0] d1_ff, e1_ff;
   logic signed [COEF_W+2*COORD_W-1:0] f1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff  <= req_channel.payload.x_coord;
         y1_ff  <= req_channel.payload.y_coord;
         ax1_ff <= coef_ff[0] * req_channel.payload.x_coord;
         bx1_ff <= coef_ff[1] * req_channel.payload.x_coord;
         by1_ff <= coef_ff[1] * req_channel.payload.y_coord;
         cy1_ff <= coef_ff[2] * req_channel.payload.y_coord;
         dx1_ff <= coef_ff[3] * req_channel.payload.x_coord;
         ey1_ff <= coef_ff[4] * req_channel.payload.y_coord;
         d1_ff  <= (COEF_W+COORD_W)'(coef_ff[3]) <<< COORD_FRAC;
         e1_ff  <= (COEF_W+COORD_W)'(coef_ff[4]) <<< COORD_FRAC;
         f1_ff  <= (COEF_W+2*COORD_W)'(coef_ff[5]) <<< (2 * COORD_FRAC);
      end
   end

   // stage 2: second products and gradient sums
   // products are formed at full 64-bit width before the sign extension
   logic signed [ACC_W-1:0] t2_ff [4];
   logic signed [ACC_W-1:0] gx2_ff, gy2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         t2_ff[0] <= ACC_W'((COEF_W+2*COORD_W)'(ax1_ff) * x1_ff);
         t2_ff[1] <= ACC_W'((COEF_W+2*COORD_W)'(bx1_ff) * y1_ff) <<< 1;
         t2_ff[2] <= ACC_W'((COEF_W+2*COORD_W)'(cy1_ff) * y1_ff);
         t2_ff[3] <= ((ACC_W'(dx1_ff) + ACC_W'(ey1_ff)) <<< (COORD_FRAC + 1)) + ACC_W'(f1_ff);
         gx2_ff   <= (ACC_W'(ax1_ff) + ACC_W'(by1_ff) + ACC_W'(d1_ff)) <<< 1;
         gy2_ff   <= (ACC_W'(bx1_ff) + ACC_W'(cy1_ff) + ACC_W'(e1_ff)) <<< 1;
      end
   end

   // stage 3: form sum, gradient rescale
   logic signed [ACC_W-1:0] q3_ff;
   logic [OUT_W:0] gx3_ff, gy3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         q3_ff  <= t2_ff[0] + t2_ff[1] + t2_ff[2] + t2_ff[3];
         gx3_ff <= rescale(gx2_ff, GF);
         gy3_ff <= rescale(gy2_ff, GF);
      end
   end

   // stage 4: form rescale, magnitudes
   logic [OUT_W:0] v4_ff, gx4_ff, gy4_ff;
   logic [OUT_W-1:0] mx4_ff, my4_ff;
   logic [OUT_W:0] v4_in;
   assign v4_in = rescale(q3_ff, QF);
   always_ff @(posedge clock) begin
      if (advance) begin
         v4_ff  <= v4_in;
         gx4_ff <= gx3_ff;
         gy4_ff <= gy3_ff;
         mx4_ff <= gx3_ff[OUT_W-1] ? -gx3_ff[OUT_W-1:0] : gx3_ff[OUT_W-1:0];
         my4_ff <= gy3_ff[OUT_W-1] ? -gy3_ff[OUT_W-1:0] : gy3_ff[OUT_W-1:0];
      end
   end

   // stage 5: squares (split into 24-bit halves)
   localparam int H = OUT_W / 2;
   logic [OUT_W-1:0] mv5_ff;
   logic [OUT_W-1:0] xp5_ff [4];
   logic [OUT_W-1:0] yp5_ff [4];
   logic [OUT_W:0] v5_ff, gx5_ff, gy5_ff;
   logic [OUT_W-1:0] mv4;
   assign mv4 = v4_ff[OUT_W-1] ? -v4_ff[OUT_W-1:0] : v4_ff[OUT_W-1:0];
   always_ff @(posedge clock) begin
      if (advance) begin
         mv5_ff <= mv4;
         xp5_ff[0] <= mx4_ff[H-1:0] * mx4_ff[H-1:0];
         xp5_ff[1] <= mx4_ff[H-1:0] * mx4_ff[OUT_W-1:H];
         xp5_ff[2] <= mx4_ff[OUT_W-1:H] * mx4_ff[OUT_W-1:H];
         xp5_ff[3] <= '0;
         yp5_ff[0] <= my4_ff[H-1:0] * my4_ff[H-1:0];
         yp5_ff[1] <= my4_ff[H-1:0] * my4_ff[OUT_W-1:H];
         yp5_ff[2] <= my4_ff[OUT_W-1:H] * my4_ff[OUT_W-1:H];
         yp5_ff[3] <= '0;
         v5_ff <= v4_ff; gx5_ff <= gx4_ff; gy5_ff <= gy4_ff;
      end
   end

   // stage 6: value square halves and denominator
   logic [PROD_W:0] den6_ff;
   logic [OUT_W-1:0] vp6_ff [3];
   logic [OUT_W:0] v6_ff, gx6_ff, gy6_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         den6_ff <= (PROD_W+1)'(xp5_ff[0]) + ((PROD_W+1)'(xp5_ff[1]) << (H + 1))
            + ((PROD_W+1)'(xp5_ff[2]) << OUT_W) + (PROD_W+1)'(xp5_ff[3])
            + (PROD_W+1)'(yp5_ff[0]) + ((PROD_W+1)'(yp5_ff[1]) << (H + 1))
            + ((PROD_W+1)'(yp5_ff[2]) << OUT_W) + (PROD_W+1)'(yp5_ff[3]);
         vp6_ff[0] <= mv5_ff[H-1:0] * mv5_ff[H-1:0];
         vp6_ff[1] <= mv5_ff[H-1:0] * mv5_ff[OUT_W-1:H];
         vp6_ff[2] <= mv5_ff[OUT_W-1:H] * mv5_ff[OUT_W-1:H];
         v6_ff <= v5_ff; gx6_ff <= gx5_ff; gy6_ff <= gy5_ff;
      end
   end

   logic [ACC_W-1:0] num6;
   assign num6 = ((ACC_W'(vp6_ff[0]) + (ACC_W'(vp6_ff[1]) << (H + 1))
      + (ACC_W'(vp6_ff[2]) << OUT_W)) << DIST_FRAC);

   // divider chain; result fields ride alongside
   logic [ACC_W-1:0] rem_w [DIV_STG+1];
   logic [ACC_W-1:0] num_w [DIV_STG+1];
   logic [QUO_W-1:0] quo_w [DIV_STG+1];
   logic [PROD_W:0]  den_ff [DIV_STG];
   logic [3*(OUT_W+1)-1:0] fld_ff [DIV_STG];
   logic             hiq_ff [DIV_STG];
   assign rem_w[0] = '0;
   assign num_w[0] = num6;
   assign quo_w[0] = '0;

   for (genvar s = 0; s < DIV_STG; s++) begin : g_div
      logic [PROD_W:0] den_src;
      logic [3*(OUT_W+1)-1:0] fld_src;
      logic hiq_src;
      if (s == 0) begin : g_first
         assign den_src = den6_ff;
         assign fld_src = {v6_ff, gx6_ff, gy6_ff};
         assign hiq_src = 1'b0;
      end else begin : g_next
         assign den_src = den_ff[s-1];
         assign fld_src = fld_ff[s-1];
         assign hiq_src = hiq_ff[s-1];
      end
      cpr_div_stage #(.BITS(DIV_BITS)) u_stage (
         .clock  (clock),
         .advance(advance),
         .rem_in (rem_w[s]),
         .num_in (num_w[s]),
         .den_in (den_src),
         .quo_in (quo_w[s]),
         .rem_out(rem_w[s+1]),
         .num_out(num_w[s+1]),
         .quo_out(quo_w[s+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[s] <= den_src;
            fld_ff[s] <= fld_src;
            // quotient bits shifted past the top mean overflow
            hiq_ff[s] <= hiq_src || (quo_w[s][QUO_W-1 -: DIV_BITS] != '0);
         end
      end
   end

   // output register
   rsp_type rsp_ff;
   logic [OUT_W:0] fv, fx, fy;
   logic gz, dsat;
   rsp_type rsp_in;
   always_comb begin
      {fv, fx, fy} = fld_ff[DIV_STG-1];
      gz = (fx[OUT_W-1:0] == '0) && (fy[OUT_W-1:0] == '0);
      dsat = !gz && (hiq_ff[DIV_STG-1] || quo_w[DIV_STG][QUO_W-1]);
      rsp_in.form_value = fv[OUT_W-1:0];
      rsp_in.grad_x     = fx[OUT_W-1:0];
      rsp_in.grad_y     = fy[OUT_W-1:0];
      rsp_in.grad_zero  = gz;
      rsp_in.sqr_dist   = (gz || dsat) ? {OUT_W{1'b1}} : quo_w[DIV_STG][OUT_W-1:0];
      rsp_in.saturated  = fv[OUT_W] || fx[OUT_W] || fy[OUT_W] || dsat;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= vld_ff[NSTG + DIV_STG - 1];
   end
   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && !rsp_channel.ready |=> rsp_channel.valid)
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.payload.grad_zero |->
         rsp_channel.payload.sqr_dist == {OUT_W{1'b1}})
      else $error("zero gradient without max distance");
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rsp_channel.payload))
      else $error("held result changed");
endmodule

// File: rtl/cpr_div_stage.sv
// Module: one registered restoring-division step group of the distance divider.
module cpr_div_stage
   import cpr_pkg::*;
#(
   parameter int BITS = 4
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [ACC_W-1:0]     rem_in,
   input  logic [ACC_W-1:0]     num_in,
   input  logic [PROD_W:0]      den_in,
   input  logic [QUO_W-1:0]     quo_in,
   output logic [ACC_W-1:0]     rem_out,
   output logic [ACC_W-1:0]     num_out,
   output logic [QUO_W-1:0]     quo_out
);
   logic [ACC_W-1:0] rem_in_v;
   logic [ACC_W-1:0] num_in_v;
   logic [QUO_W-1:0] quo_in_v;
   logic [ACC_W:0]   trial;
   logic [ACC_W-1:0] rem_ff;
   logic [ACC_W-1:0] num_ff;
   logic [QUO_W-1:0] quo_ff;

   always_comb begin
      rem_in_v = rem_in;
      num_in_v = num_in;
      quo_in_v = quo_in;
      trial = '0;
      for (int i = 0; i < BITS; i++) begin
         trial = {rem_in_v, num_in_v[ACC_W-1]} - {{(ACC_W-PROD_W){1'b0}}, den_in};
         if (!trial[ACC_W]) begin
            rem_in_v = trial[ACC_W-1:0];
            quo_in_v = {quo_in_v[QUO_W-2:0], 1'b1};
         end else begin
            rem_in_v = {rem_in_v[ACC_W-2:0], num_in_v[ACC_W-1]};
            quo_in_v = {quo_in_v[QUO_W-2:0], 1'b0};
         end
         num_in_v = {num_in_v[ACC_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_v;
         num_ff <= num_in_v;
         quo_ff <= quo_in_v;
      end
   end
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign quo_out = quo_ff;
endmodule

// File: bench/residual_checker.sv
// Checker: watches the point and result channels, predicts each result and compares.
module residual_checker
   import cpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   output int                   fail_count,
   output int                   waiting
);
   localparam logic signed [127:0] POS_MAX = (128'sd1 <<< 47) - 1;
   localparam logic signed [127:0] NEG_MIN = -(128'sd1 <<< 47);
   localparam logic [127:0]        DIST_MAX = (128'd1 << 48) - 1;

   logic signed [COEF_W-1:0] coef [NUM_COEF];
   rsp_type                  expected_rsp [$];
   int                       mismatches;

   // round half up by k bits, then clip to 48 bits
   function automatic logic signed [OUT_W-1:0] round_clip(
      input logic signed [127:0] v, input int k, inout bit sat);
      logic signed [127:0] r;
      r = (v + (128'sd1 <<< (k - 1))) >>> k;
      if (r > POS_MAX) begin
         sat = 1;
         r = POS_MAX;
      end else if (r < NEG_MIN) begin
         sat = 1;
         r = NEG_MIN;
      end
      return r[OUT_W-1:0];
   endfunction

   function automatic rsp_type predict_residual(input req_type p);
      logic signed [127:0] ca, cb, cc, cd, ce, cf, px, py, unit, q, gxw, gyw;
      logic signed [127:0] sv, sx, sy;
      logic [127:0]        mv, mx, my, num, den, quo;
      bit                  sat;
      rsp_type             r;
      sat = 0;
      ca = coef[REG_COEF_A]; cb = coef[REG_COEF_B]; cc = coef[REG_COEF_C];
      cd = coef[REG_COEF_D]; ce = coef[REG_COEF_E]; cf = coef[REG_COEF_F];
      px = p.x_coord; py = p.y_coord;
      unit = 128'sd1 <<< COORD_FRAC_DEF;
      q = ca * px * px + 2 * cb * px * py + cc * py * py
          + 2 * cd * px * unit + 2 * ce * py * unit + cf * unit * unit;
      gxw = 2 * (ca * px + cb * py + cd * unit);
      gyw = 2 * (cb * px + cc * py + ce * unit);
      r.form_value = round_clip(q, COEF_FRAC_DEF + 2 * COORD_FRAC_DEF - OUT_FRAC_DEF, sat);
      r.grad_x = round_clip(gxw, COEF_FRAC_DEF + COORD_FRAC_DEF - OUT_FRAC_DEF, sat);
      r.grad_y = round_clip(gyw, COEF_FRAC_DEF + COORD_FRAC_DEF - OUT_FRAC_DEF, sat);
      r.grad_zero = (r.grad_x == 0) && (r.grad_y == 0);
      if (r.grad_zero) begin
         r.sqr_dist = DIST_MAX[OUT_W-1:0];
      end else begin
         sv = r.form_value; sx = r.grad_x; sy = r.grad_y;
         mv = (sv < 0) ? -sv : sv;
         mx = (sx < 0) ? -sx : sx;
         my = (sy < 0) ? -sy : sy;
         num = (mv * mv) << DIST_FRAC;
         den = mx * mx + my * my;
         quo = num / den;
         if (quo > DIST_MAX) begin
            sat = 1;
            quo = DIST_MAX;
         end
         r.sqr_dist = quo[OUT_W-1:0];
      end
      r.saturated = sat;
      return r;
   endfunction

   assign fail_count = mismatches;
   assign waiting    = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (coef[i]) coef[i] <= '0;
      end else begin
         if (csr_write_enable && csr_index < NUM_COEF)
            coef[csr_index] <= csr_write_data;
         if (req_valid && req_ready)
            expected_rsp.push_back(predict_residual(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result with no request waiting");
               mismatches++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_payload.form_value !== e.form_value) begin
                  $error("form_value exp %h got %h", e.form_value, rsp_payload.form_value);
                  mismatches++;
               end
               if (rsp_payload.grad_x !== e.grad_x) begin
                  $error("grad_x exp %h got %h", e.grad_x, rsp_payload.grad_x);
                  mismatches++;
               end
               if (rsp_payload.grad_y !== e.grad_y) begin
                  $error("grad_y exp %h got %h", e.grad_y, rsp_payload.grad_y);
                  mismatches++;
               end
               if (rsp_payload.sqr_dist !== e.sqr_dist) begin
                  $error("sqr_dist exp %h got %h", e.sqr_dist, rsp_payload.sqr_dist);
                  mismatches++;
               end
               if (rsp_payload.grad_zero !== e.grad_zero) begin
                  $error("grad_zero exp %b got %b", e.grad_zero, rsp_payload.grad_zero);
                  mismatches++;
               end
               if (rsp_payload.saturated !== e.saturated) begin
                  $error("saturated exp %b got %b", e.saturated, rsp_payload.saturated);
                  mismatches++;
               end
            end
         end
      end
   end
endmodule

// File: bench/tb.sv
// Testbench top: drives points and coefficient writes into the conic residual block.
module tb;
   import cpr_pkg::*;

   localparam int PIPE_DRAIN = 40;        // drain wait, longer than the pipeline latency, leave margin
   localparam int RANDOM_PHASES = 6;
   localparam int POINTS_PER_PHASE = 220;
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX = NUM_COEF + 1;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0] csr_write_data = '0;
   bit quiet = 0;                         // no idling in the final stretch
   int fail_count, waiting, points_sent, settings_used;
   int stall_left;

   cpr_stream_if #(.payload_type(req_type)) req_if ();
   cpr_stream_if #(.payload_type(rsp_type)) rsp_if ();

   conic_point_residual DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_channel(req_if), .rsp_channel(rsp_if)
   );

   residual_checker checker_inst (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload),
      .fail_count(fail_count), .waiting(waiting)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.payload = '0;
      rsp_if.ready = 1;
      stall_left = 0;
   end

   // Result side back-pressure: random stall bursts of random length.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_if.ready <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= (stall_left == 0);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13);
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= 1;
      end
   end

   // One request; an idle burst may come first. valid stays up between
   // back-to-back requests so it is never dropped and raised in one step.
   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.payload <= '{x_coord: x, y_coord: y};
      do @(posedge clock); while (!req_if.ready);
      points_sent++;
   endtask

   // Pipe must be empty before coefficients change.
   task automatic drain_pipe();
      req_if.valid <= 0;
      @(posedge clock);
      wait (waiting == 0);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic load_conic(input logic [COEF_W-1:0] a, b, c, d, e, f);
      drain_pipe();
      write_coef(REG_COEF_A, a);
      write_coef(REG_COEF_B, b);
      write_coef(REG_COEF_C, c);
      write_coef(REG_COEF_D, d);
      write_coef(REG_COEF_E, e);
      write_coef(REG_COEF_F, f);
      settings_used++;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Coefficients: mostly modest magnitudes, some full range.
   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
         2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return 32'(signed'($urandom_range(0, 1 << 30)) - (1 << 29));
      endcase
   endfunction

   initial begin
      points_sent = 0;
      settings_used = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset coefficients are all zero: gradient zero, distance pinned.
      send_point(16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h8000);

      // Circle of radius 4: center gives zero gradient, nonzero form.
      load_conic(32'h0100_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'hF000_0000);
      send_point(16'h0000, 16'h0000);
      send_point(16'h0040, 16'h0000);   // on the curve
      send_point(16'h0000, 16'hFFC0);
      send_point(16'h0023, 16'h0011);
      send_point(16'h7FFF, 16'h7FFF);
      // Unknown register index must be ignored.
      drain_pipe();
      write_coef(UNUSED_INDEX, 32'hFFFF_FFFF);
      send_point(16'h0010, 16'h0010);

      // Extremes: all max, then all min, to force clipping.
      load_conic(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'h0000, 16'h0000);
      load_conic(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(16'h7FFF, 16'h8000);
      send_point(16'h8000, 16'h8000);
      send_point(16'h0000, 16'h0000);
      send_point(16'h0001, 16'hFFFF);
      // Tiny coefficients: gradient rounds to zero though not exactly zero.
      load_conic(32'h0000_0001, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0000_0100);
      send_point(16'h0003, 16'h0002);
      send_point(16'hFFFF, 16'hFFFF);

      // Random conics with random points.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_conic(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                    pick_coef());
         if (ph == RANDOM_PHASES - 1) quiet = 1;
         for (int i = 0; i < POINTS_PER_PHASE; i++)
            send_point(pick_coord(), pick_coord());
      end

      // Last setting back to zero so every register ends written at zero too.
      load_conic(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_point(pick_coord(), pick_coord());
      drain_pipe();

      $display("%0d points over %0d coefficient settings, random stalls on both sides",
               points_sent, settings_used);
      if (fail_count == 0 && waiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end
endmodule
